// File: rtl/gaussian_blur_3x3_stream_assert.svh
// Assertion macros for the 3x3 blur stream block.
// Used by the port checker; needs nothing else.
`ifndef GAUSSIAN_BLUR_3X3_STREAM_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_STREAM_ASSERT_SVH

// check cons in the same cycle as ante
`define GB3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define GB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gb3_pkg.sv
// Shared types, constants and kernel arithmetic of the 3x3 blur stream block.
// No dependencies.
`timescale 1ns / 1ps

package gb3_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 10;
    localparam int COL_OUT_W   = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int VSUM_W      = 10;
    localparam int HSUM_W      = 12;
    localparam int RES_N       = 4;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_WIDTH     = 3;
    localparam int MIN_HEIGHT    = 2;
    localparam int RESET_WIDTH   = 1000;
    localparam int RESET_HEIGHT  = 1000;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        logic r_ge1;
        logic r_le1;
        logic r_last;
        logic c_ge1;
        logic c_last;
        logic c_one;
    } pos_flags_t;

    typedef struct packed {
        pixel_t                 pixel;
        logic [ROW_W-1:0]       row;
        logic [COL_OUT_W-1:0]   col;
    } result_t;

    function automatic logic [VSUM_W-1:0] vsum_mid(column_t c);
        vsum_mid = VSUM_W'(c.top) + (VSUM_W'(c.mid) << 1) + VSUM_W'(c.bot);
    endfunction

    function automatic logic [VSUM_W-1:0] vsum_bot(column_t c);
        vsum_bot = VSUM_W'(c.mid) + VSUM_W'(c.bot) + (VSUM_W'(c.bot) << 1);
    endfunction

    function automatic pixel_t blur(logic [VSUM_W-1:0] l, logic [VSUM_W-1:0] m,
                                    logic [VSUM_W-1:0] r);
        logic [HSUM_W-1:0] s;
        s = HSUM_W'(l) + (HSUM_W'(m) << 1) + HSUM_W'(r) + HSUM_W'(8);
        blur = s[HSUM_W-1:4];
    endfunction

endpackage

// File: rtl/gb3_stream_if.sv
// Valid/ready stream interfaces for the blur block's input and result channels.
// Depends on gb3_pkg.
`timescale 1ns / 1ps

interface gb3_in_if;
    logic                 valid;
    logic                 ready;
    gb3_pkg::pixel_t      pixel_in;
    logic                 frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface gb3_out_if;
    logic                            valid;
    logic                            ready;
    gb3_pkg::pixel_t                 pixel_out;
    logic [gb3_pkg::ROW_W-1:0]       out_row;
    logic [gb3_pkg::COL_OUT_W-1:0]   out_col;
    logic                            last_of_run;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output last_of_run, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input last_of_run, output ready);
endinterface

// File: rtl/gb3_window.sv
// 3x3 window columns and the 1-2-1 kernel for the four possible results of an item.
// Depends on gb3_pkg.
`timescale 1ns / 1ps

module gb3_window (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  gb3_pkg::column_t                       new_col,
    input  logic                                   left_edge,
    output gb3_pkg::pixel_t [gb3_pkg::RES_N-1:0]   pix
);

    gb3_pkg::column_t win_a_reg;
    gb3_pkg::column_t win_b_reg;

    logic [gb3_pkg::VSUM_W-1:0] vm0, vm1, vm2;
    logic [gb3_pkg::VSUM_W-1:0] vb0, vb1, vb2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_a_reg <= '0;
            win_b_reg <= '0;
        end
        else if (advance)
        begin
            win_a_reg <= win_b_reg;
            win_b_reg <= new_col;
        end
    end

    always_comb
    begin
        vm0 = gb3_pkg::vsum_mid(win_a_reg);
        vm1 = gb3_pkg::vsum_mid(win_b_reg);
        vm2 = gb3_pkg::vsum_mid(new_col);
        vb0 = gb3_pkg::vsum_bot(win_a_reg);
        vb1 = gb3_pkg::vsum_bot(win_b_reg);
        vb2 = gb3_pkg::vsum_bot(new_col);
        // previous column: replicate center at the left edge
        pix[0] = gb3_pkg::blur(left_edge ? vm1 : vm0, vm1, vm2);
        pix[1] = gb3_pkg::blur(left_edge ? vb1 : vb0, vb1, vb2);
        // current column at the right edge: replicate center
        pix[2] = gb3_pkg::blur(vm1, vm2, vm2);
        pix[3] = gb3_pkg::blur(vb1, vb2, vb2);
    end

endmodule

// File: rtl/gaussian_blur_3x3_stream.sv
// Top level of the streaming 3x3 Gaussian blur (1-2-1 by 1-2-1, rounded).
// Depends on gb3_pkg, gb3_stream_if and gb3_window.
//
// Usage:
//   in_ch takes one 8-bit pixel per item in raster order; frame_start puts the
//   pixel at row 0, column 0. out_ch gives blurred pixels with their row and
//   column; last_of_run marks the final result caused by one input item.
//   Results trail the input by one row and one column; a row end flushes the
//   last column and the last row is produced together with the row above, so
//   one item causes zero to four results.
//   image_width (index 0) and image_height (index 1) are written through the
//   cfg port and take effect at the next row 0, column 0 pixel.
// Timing:
//   One item per cycle while out_ch is ready and each item causes at most one
//   result; an item with several results holds the next item in the read stage
//   and so blocks the input until only its last result is left and is taken.
//   Each item passes the line store read stage, then the result register.
//   Reset empties the pipeline, zeroes the window and position, and loads the
//   registers with 1000 x 1000. Line stores need no clearing.
//   When out_ch stalls, the result stage holds and the input is blocked once
//   the stage behind it is full.
`timescale 1ns / 1ps

module gaussian_blur_3x3_stream #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gb3_in_if.sink                            in_ch,
    gb3_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gb3_pkg::CFG_W-1:0]         cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int AW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = (AW > gb3_pkg::CFG_W) ? AW : gb3_pkg::CFG_W;
    localparam int RST_W = (gb3_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                              : gb3_pkg::RESET_WIDTH;
    localparam int ROW_W = gb3_pkg::ROW_W;
    localparam int HW    = gb3_pkg::CFG_W;

    // configuration
    logic [gb3_pkg::CFG_W-1:0] width_reg;
    logic [gb3_pkg::CFG_W-1:0] height_reg;
    logic [AW-1:0]             act_w_reg;
    logic [HW-1:0]             act_h_reg;

    // position
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [CW-1:0]    col_cnt_reg, col_cnt_next;

    // read stage
    logic                s1_valid_reg;
    gb3_pkg::pixel_t     s1_px_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [CW-1:0]       s1_col_reg;
    gb3_pkg::pos_flags_t s1_flags_reg;
    gb3_pkg::pixel_t     newer_rd_reg;
    gb3_pkg::pixel_t     older_rd_reg;

    // result stage
    logic [gb3_pkg::RES_N-1:0] mask_reg, mask_next;
    gb3_pkg::result_t          res_reg [gb3_pkg::RES_N];

    gb3_pkg::pixel_t newer_mem [MAX_WIDTH];
    gb3_pkg::pixel_t older_mem [MAX_WIDTH];

    logic                in_fire, s1_fire, out_fire, s2_free, s2_single, fwd;
    logic                at_origin;
    logic [ROW_W-1:0]    r_cur;
    logic [CW-1:0]       c_cur, c_sel;
    logic [AW-1:0]       w_clamp, act_w_eff, c_lim;
    logic [HW-1:0]       h_clamp, act_h_eff;
    gb3_pkg::pos_flags_t flags;
    gb3_pkg::column_t    new_col;
    gb3_pkg::pixel_t [gb3_pkg::RES_N-1:0] pix;
    logic [1:0]          sel;
    logic [gb3_pkg::RES_N-1:0] sel_oh, mask_load;
    logic [ROW_W-1:0]    row_prev;
    logic [gb3_pkg::COL_OUT_W-1:0] col_prev, col_curr;

    // handshakes
    always_comb
    begin
        out_fire  = out_ch.valid && out_ch.ready;
        s2_single = (mask_reg & (mask_reg - gb3_pkg::RES_N'(1))) == '0;
        s2_free   = (mask_reg == '0) || (s2_single && out_ch.ready);
        s1_fire   = s1_valid_reg && s2_free;
        in_ch.ready = !s1_valid_reg || s1_fire;
        in_fire   = in_ch.valid && in_ch.ready;
    end

    // clamp configured sizes
    always_comb
    begin
        if (XW'(width_reg) < XW'(gb3_pkg::MIN_WIDTH))
            w_clamp = AW'(gb3_pkg::MIN_WIDTH);
        else if (XW'(width_reg) > XW'(MAX_WIDTH))
            w_clamp = AW'(MAX_WIDTH);
        else
            w_clamp = AW'(width_reg);

        if (height_reg < HW'(gb3_pkg::MIN_HEIGHT))
            h_clamp = HW'(gb3_pkg::MIN_HEIGHT);
        else if (height_reg > HW'(gb3_pkg::MAX_HEIGHT))
            h_clamp = HW'(gb3_pkg::MAX_HEIGHT);
        else
            h_clamp = height_reg;
    end

    // position of the incoming item
    always_comb
    begin
        r_cur     = in_ch.frame_start ? '0 : row_cnt_reg;
        c_cur     = in_ch.frame_start ? '0 : col_cnt_reg;
        at_origin = (r_cur == '0) && (c_cur == '0);
        act_w_eff = at_origin ? w_clamp : act_w_reg;
        act_h_eff = at_origin ? h_clamp : act_h_reg;
        c_lim     = act_w_eff - AW'(1);
        c_sel     = (AW'(c_cur) >= act_w_eff) ? CW'(c_lim) : c_cur;

        flags.r_ge1  = r_cur != '0;
        flags.r_le1  = r_cur <= ROW_W'(1);
        flags.r_last = HW'(r_cur) == (act_h_eff - HW'(1));
        flags.c_ge1  = c_sel != '0;
        flags.c_last = AW'(c_sel) == c_lim;
        flags.c_one  = c_sel == CW'(1);

        if (flags.c_last)
        begin
            col_cnt_next = '0;
            row_cnt_next = flags.r_last ? '0 : r_cur + ROW_W'(1);
        end
        else
        begin
            col_cnt_next = c_sel + CW'(1);
            row_cnt_next = r_cur;
        end

        fwd = s1_fire && (s1_col_reg == c_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= gb3_pkg::CFG_W'(gb3_pkg::RESET_WIDTH);
            height_reg   <= gb3_pkg::CFG_W'(gb3_pkg::RESET_HEIGHT);
            act_w_reg    <= AW'(RST_W);
            act_h_reg    <= HW'(gb3_pkg::RESET_HEIGHT);
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_flags_reg <= '0;
            mask_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gb3_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    gb3_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                row_cnt_reg  <= row_cnt_next;
                col_cnt_reg  <= col_cnt_next;
                act_w_reg    <= act_w_eff;
                act_h_reg    <= act_h_eff;
                s1_flags_reg <= flags;
            end
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            mask_reg <= mask_next;
        end
    end

    // line stores: write the leaving item, read for the arriving one
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            newer_mem[s1_col_reg] <= s1_px_reg;
            older_mem[s1_col_reg] <= newer_rd_reg;
        end
        if (in_fire)
        begin
            newer_rd_reg <= fwd ? s1_px_reg : newer_mem[c_sel];
            older_rd_reg <= fwd ? newer_rd_reg : older_mem[c_sel];
            s1_px_reg    <= in_ch.pixel_in;
            s1_row_reg   <= r_cur;
            s1_col_reg   <= c_sel;
        end
    end

    always_comb
    begin
        new_col.top = s1_flags_reg.r_le1 ? newer_rd_reg : older_rd_reg;
        new_col.mid = newer_rd_reg;
        new_col.bot = s1_px_reg;
    end

    gb3_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_fire),
        .new_col   (new_col),
        .left_edge (s1_flags_reg.c_one),
        .pix       (pix)
    );

    // result stage load and drain
    always_comb
    begin
        row_prev = s1_row_reg - ROW_W'(1);
        col_prev = gb3_pkg::COL_OUT_W'(s1_col_reg - CW'(1));
        col_curr = gb3_pkg::COL_OUT_W'(s1_col_reg);

        mask_load[0] = s1_flags_reg.r_ge1 && s1_flags_reg.c_ge1;
        mask_load[1] = s1_flags_reg.r_ge1 && s1_flags_reg.c_ge1 && s1_flags_reg.r_last;
        mask_load[2] = s1_flags_reg.r_ge1 && s1_flags_reg.c_last;
        mask_load[3] = s1_flags_reg.r_ge1 && s1_flags_reg.c_last && s1_flags_reg.r_last;

        if (mask_reg[0])
            sel = 2'd0;
        else if (mask_reg[1])
            sel = 2'd1;
        else if (mask_reg[2])
            sel = 2'd2;
        else
            sel = 2'd3;
        sel_oh = gb3_pkg::RES_N'(1) << sel;

        if (s1_fire)
            mask_next = mask_load;
        else if (out_fire)
            mask_next = mask_reg & ~sel_oh;
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_reg[0] <= '{pixel: pix[0], row: row_prev,   col: col_prev};
            res_reg[1] <= '{pixel: pix[1], row: s1_row_reg, col: col_prev};
            res_reg[2] <= '{pixel: pix[2], row: row_prev,   col: col_curr};
            res_reg[3] <= '{pixel: pix[3], row: s1_row_reg, col: col_curr};
        end
    end

    always_comb
    begin
        out_ch.valid       = mask_reg != '0;
        out_ch.pixel_out   = res_reg[sel].pixel;
        out_ch.out_row     = res_reg[sel].row;
        out_ch.out_col     = res_reg[sel].col;
        out_ch.last_of_run = (mask_reg & ~sel_oh) == '0;
    end

endmodule

// File: rtl/gb3_checker.sv
// Port-level checks for the 3x3 blur stream block, bound to its top level.
// Depends on gb3_pkg and gaussian_blur_3x3_stream_assert.svh.
`timescale 1ns / 1ps
`include "gaussian_blur_3x3_stream_assert.svh"

module gb3_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  gb3_pkg::pixel_t                   out_pixel,
    input  logic [gb3_pkg::ROW_W-1:0]         out_row,
    input  logic [gb3_pkg::COL_OUT_W-1:0]     out_col,
    input  logic                              out_last
);

    `GB3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel) && $stable(out_row) && $stable(out_col) && $stable(out_last), "result changed while stalled")

    `GB3_ASSERT_NOW(a_block_only_when_pending, clk, rst_n, !in_ready, out_valid, "input blocked with no result pending")

    `GB3_ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid && out_ready && !out_last, out_valid, "run ended without last_of_run")

endmodule

bind gaussian_blur_3x3_stream gb3_checker u_gb3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pixel (out_ch.pixel_out),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_last  (out_ch.last_of_run)
);
